[hw/rtl/fqri_pkg.sv]
// shared types, constants and codes of the fastq record index scanner
`timescale 1ns / 1ps

package fqri_pkg;

    localparam int OFFSET_BITS     = 48;
    localparam int NAME_LEN_BITS   = 16;
    localparam int BASE_BITS       = 40;
    localparam int SEQ_TOTAL_BITS  = BASE_BITS + 1;
    localparam int LINE_CNT_BITS   = 31;
    localparam int LINE_BITS       = 32;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;

    typedef enum logic [1:0] {
        KIND_INDEX = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_NAME     = 3'd1,
        ERR_EOF_NAME    = 3'd2,
        ERR_EMPTY_SEQ   = 3'd3,
        ERR_SEQ_LEN     = 3'd4,
        ERR_EMPTY_QUAL  = 3'd5,
        ERR_QUAL_LEN    = 3'd6,
        ERR_NO_RECORD   = 3'd7
    } err_t;

    typedef struct packed {
        logic [1:0]                   result_kind;
        logic [2:0]                   error_code;
        logic [OFFSET_BITS-1:0]       name_start;
        logic [NAME_LEN_BITS-1:0]     name_length;
        logic [BASE_BITS-1:0]         base_count;
        logic signed [LINE_BITS-1:0]  line_bytes;
        logic signed [LINE_BITS-1:0]  line_bases;
        logic [OFFSET_BITS-1:0]       sequence_start;
        logic [OFFSET_BITS-1:0]       quality_start;
        logic                         last_of_run;
    } result_t;

    // up to two results written into the result queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[hw/rtl/fqri_channels.sv]
// valid/ready channel interfaces for the byte stream and the index results
`timescale 1ns / 1ps

interface fqri_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface fqri_result_if import fqri_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   result_kind;
    logic [2:0]                   error_code;
    logic [OFFSET_BITS-1:0]       name_start;
    logic [NAME_LEN_BITS-1:0]     name_length;
    logic [BASE_BITS-1:0]         base_count;
    logic signed [LINE_BITS-1:0]  line_bytes;
    logic signed [LINE_BITS-1:0]  line_bases;
    logic [OFFSET_BITS-1:0]       sequence_start;
    logic [OFFSET_BITS-1:0]       quality_start;
    logic                         last_of_run;

    modport source (
        output valid, output result_kind, output error_code, output name_start,
        output name_length, output base_count, output line_bytes, output line_bases,
        output sequence_start, output quality_start, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input result_kind, input error_code, input name_start,
        input name_length, input base_count, input line_bytes, input line_bases,
        input sequence_start, input quality_start, input last_of_run,
        output ready
    );
endinterface

[hw/rtl/fqri_scanner.sv]
// record state machine: per-byte state update and result generation
`timescale 1ns / 1ps

module fqri_scanner import fqri_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_valid,
    input  logic [7:0] step_byte,
    input  logic       step_eos,
    output push_t      push
);

    typedef enum logic [7:0] {
        M_SEQ        = 8'b0000_0001,
        M_NAME       = 8'b0000_0010,
        M_LASTSEQ    = 8'b0000_0100,
        M_BEYONDSEQ  = 8'b0000_1000,
        M_QHEAD      = 8'b0001_0000,
        M_QUAL       = 8'b0010_0000,
        M_LASTQUAL   = 8'b0100_0000,
        M_BEYONDQUAL = 8'b1000_0000
    } mode_t;

    typedef enum logic [6:0] {
        P_START    = 7'b000_0001,
        P_NAMEWAIT = 7'b000_0010,
        P_NAME     = 7'b000_0100,
        P_HDRREST  = 7'b000_1000,
        P_PLUSREST = 7'b001_0000,
        P_SEQLINE  = 7'b010_0000,
        P_QUALLINE = 7'b100_0000
    } phase_t;

    localparam logic [OFFSET_BITS-1:0]    OFF_MAX      = {OFFSET_BITS{1'b1}};
    localparam logic [NAME_LEN_BITS-1:0]  NAME_MAX     = {NAME_LEN_BITS{1'b1}};
    localparam logic [LINE_CNT_BITS-1:0]  LINE_CNT_MAX = {LINE_CNT_BITS{1'b1}};
    localparam logic [SEQ_TOTAL_BITS-1:0] BASE_SAT     = {1'b0, {BASE_BITS{1'b1}}};
    localparam int                        SUM_PAD      = SEQ_TOTAL_BITS + 1 - LINE_CNT_BITS;

    mode_t                      mode_reg, mode_next;
    phase_t                     phase_reg, phase_next;
    logic [OFFSET_BITS-1:0]     pos_reg, pos_next;
    logic [SEQ_TOTAL_BITS-1:0]  stot_reg, stot_next;
    logic [LINE_BITS-1:0]       flb_reg, flb_next;
    logic [LINE_BITS-1:0]       flba_reg, flba_next;
    logic [LINE_CNT_BITS-1:0]   clb_reg, clb_next;
    logic [LINE_CNT_BITS-1:0]   clba_reg, clba_next;
    logic [OFFSET_BITS-1:0]     sstart_reg, sstart_next;
    logic [OFFSET_BITS-1:0]     qstart_reg, qstart_next;
    logic [OFFSET_BITS-1:0]     nstart_reg, nstart_next;
    logic [NAME_LEN_BITS-1:0]   nlen_reg, nlen_next;
    logic                       nseen_reg, nseen_next;
    logic                       halted_reg, halted_next;

    logic [OFFSET_BITS-1:0]     pos_adv;
    logic [LINE_CNT_BITS-1:0]   l1;
    logic [LINE_CNT_BITS-1:0]   l2;
    logic                       line_match;
    logic [SEQ_TOTAL_BITS:0]    seq_sum;
    logic [SEQ_TOTAL_BITS-1:0]  seq_total_sum;
    logic [LINE_CNT_BITS-1:0]   line_bytes_inc;
    logic [LINE_CNT_BITS-1:0]   line_bases_inc;
    logic                       byte_print;
    logic                       byte_space;
    logic                       seq_side;
    logic                       seq_end_err;
    logic                       qual_end_err;
    mode_t                      seq_end_mode;
    mode_t                      qual_end_mode;
    err_t                       err;

    function automatic result_t make_record(
        input logic [OFFSET_BITS-1:0]    nstart,
        input logic [NAME_LEN_BITS-1:0]  nlen,
        input logic [SEQ_TOTAL_BITS-1:0] stot,
        input logic [LINE_BITS-1:0]      flb,
        input logic [LINE_BITS-1:0]      flba,
        input logic [OFFSET_BITS-1:0]    sstart,
        input logic [OFFSET_BITS-1:0]    qstart,
        input logic                      last
    );
        result_t r;
        r = '0;
        r.result_kind    = KIND_INDEX;
        r.error_code     = ERR_NONE;
        r.name_start     = nstart;
        r.name_length    = nlen;
        r.base_count     = stot[BASE_BITS-1:0];
        r.line_bytes     = flb;
        r.line_bases     = flba;
        r.sequence_start = sstart;
        r.quality_start  = qstart;
        r.last_of_run    = last;
        return r;
    endfunction

    function automatic result_t make_status(
        input kind_t kind,
        input err_t  code
    );
        result_t r;
        r = '0;
        r.result_kind = kind;
        r.error_code  = code;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    always_comb
    begin
        pos_adv    = (pos_reg != OFF_MAX) ? pos_reg + 1'b1 : pos_reg;
        l1         = (clb_reg != LINE_CNT_MAX) ? clb_reg + 1'b1 : LINE_CNT_MAX;
        l2         = clba_reg;
        line_match = ({1'b0, l1} == flb_reg) && ({1'b0, l2} == flba_reg);

        // saturating add onto a total that may still be minus one
        seq_sum = {stot_reg[SEQ_TOTAL_BITS-1], stot_reg} + {{SUM_PAD{1'b0}}, l2};
        if (seq_sum[SEQ_TOTAL_BITS])
            seq_total_sum = seq_sum[SEQ_TOTAL_BITS-1:0];
        else if (seq_sum[SEQ_TOTAL_BITS-1])
            seq_total_sum = BASE_SAT;
        else
            seq_total_sum = seq_sum[SEQ_TOTAL_BITS-1:0];

        byte_print = (step_byte >= 8'h21) && (step_byte <= 8'h7E);
        byte_space = (step_byte == 8'h20) || ((step_byte >= 8'h09) && (step_byte <= 8'h0D));
        line_bytes_inc = (clb_reg != LINE_CNT_MAX) ? clb_reg + 1'b1 : clb_reg;
        line_bases_inc = (byte_print && (clba_reg != LINE_CNT_MAX)) ? clba_reg + 1'b1
                                                                     : clba_reg;

        seq_side = (mode_reg == M_SEQ) || (mode_reg == M_NAME) ||
                   (mode_reg == M_LASTSEQ) || (mode_reg == M_BEYONDSEQ);

        seq_end_err  = (mode_reg == M_BEYONDSEQ) && (l2 != '0);
        qual_end_err = (mode_reg == M_BEYONDQUAL) && (l2 != '0);

        case (mode_reg)
            M_NAME:  seq_end_mode = M_SEQ;
            M_SEQ:   seq_end_mode = line_match ? M_SEQ : M_LASTSEQ;
            default: seq_end_mode = mode_reg;
        endcase

        case (mode_reg)
            M_QHEAD, M_QUAL: qual_end_mode = line_match ? M_QUAL : M_LASTQUAL;
            default:         qual_end_mode = mode_reg;
        endcase

        mode_next   = mode_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        stot_next   = stot_reg;
        flb_next    = flb_reg;
        flba_next   = flba_reg;
        clb_next    = clb_reg;
        clba_next   = clba_reg;
        sstart_next = sstart_reg;
        qstart_next = qstart_reg;
        nstart_next = nstart_reg;
        nlen_next   = nlen_reg;
        nseen_next  = nseen_reg;
        halted_next = halted_reg;
        err         = ERR_NONE;
        push        = '0;

        if (step_valid && step_eos)
        begin
            if (!halted_reg)
            begin
                // close whatever line is open
                case (phase_reg)
                    P_NAMEWAIT, P_NAME:
                        err = ERR_EOF_NAME;
                    P_HDRREST:
                        sstart_next = pos_reg;
                    P_PLUSREST:
                        qstart_next = pos_reg;
                    P_SEQLINE:
                    begin
                        if (seq_end_err)
                            err = ERR_SEQ_LEN;
                        else
                        begin
                            stot_next = seq_total_sum;
                            mode_next = seq_end_mode;
                            if (mode_reg == M_NAME)
                            begin
                                flb_next  = {1'b0, l1};
                                flba_next = {1'b0, l2};
                            end
                        end
                    end
                    P_QUALLINE:
                    begin
                        if (qual_end_err)
                            err = ERR_QUAL_LEN;
                    end
                    default:
                        err = ERR_NONE;
                endcase

                if (err == ERR_NONE)
                begin
                    if (!stot_next[SEQ_TOTAL_BITS-1])
                    begin
                        if (!nseen_reg)
                            err = ERR_NO_NAME;
                        else
                        begin
                            push.count  = 2'd2;
                            push.first  = make_record(nstart_reg, nlen_reg, stot_next,
                                                      flb_next, flba_next, sstart_next,
                                                      qstart_next, 1'b0);
                            push.second = make_status(KIND_DONE, ERR_NONE);
                        end
                    end
                    else
                        err = ERR_NO_RECORD;
                end

                if (err != ERR_NONE)
                begin
                    push.count = 2'd1;
                    push.first = make_status(KIND_ERROR, err);
                end
            end

            // end marker always returns the block to its reset state
            mode_next   = M_SEQ;
            phase_next  = P_START;
            pos_next    = '0;
            stot_next   = '1;
            flb_next    = '1;
            flba_next   = '1;
            clb_next    = '0;
            clba_next   = '0;
            sstart_next = '0;
            qstart_next = '0;
            nstart_next = '0;
            nlen_next   = '0;
            nseen_next  = 1'b0;
            halted_next = 1'b0;
        end
        else if (step_valid && !halted_reg)
        begin
            case (phase_reg)
                P_START:
                begin
                    if (step_byte == CHAR_NEWLINE)
                    begin
                        if (mode_reg == M_NAME)
                            sstart_next = pos_adv;
                        else if ((mode_reg == M_SEQ) && !stot_reg[SEQ_TOTAL_BITS-1])
                            mode_next = M_LASTSEQ;
                    end
                    else if (step_byte == CHAR_AT)
                    begin
                        if (!stot_reg[SEQ_TOTAL_BITS-1] && !nseen_reg)
                            err = ERR_NO_NAME;
                        else
                        begin
                            // a new header flushes the record before it
                            if (!stot_reg[SEQ_TOTAL_BITS-1])
                            begin
                                push.count = 2'd1;
                                push.first = make_record(nstart_reg, nlen_reg, stot_reg,
                                                         flb_reg, flba_reg, sstart_reg,
                                                         qstart_reg, 1'b1);
                            end
                            nseen_next  = 1'b1;
                            nlen_next   = '0;
                            nstart_next = pos_adv;
                            phase_next  = P_NAMEWAIT;
                        end
                    end
                    else if (step_byte == CHAR_PLUS)
                    begin
                        mode_next  = M_QHEAD;
                        phase_next = P_PLUSREST;
                    end
                    else if (seq_side)
                    begin
                        if (mode_reg == M_BEYONDSEQ)
                            err = ERR_EMPTY_SEQ;
                        else
                        begin
                            if (mode_reg == M_LASTSEQ)
                                mode_next = M_BEYONDSEQ;
                            clb_next   = LINE_CNT_BITS'(1);
                            clba_next  = LINE_CNT_BITS'(byte_print);
                            phase_next = P_SEQLINE;
                        end
                    end
                    else
                    begin
                        if (mode_reg == M_BEYONDQUAL)
                            err = ERR_EMPTY_QUAL;
                        else
                        begin
                            if (mode_reg == M_LASTQUAL)
                                mode_next = M_BEYONDQUAL;
                            clb_next   = LINE_CNT_BITS'(1);
                            clba_next  = LINE_CNT_BITS'(byte_print);
                            phase_next = P_QUALLINE;
                        end
                    end
                end
                P_NAMEWAIT:
                begin
                    if (!byte_space)
                    begin
                        nstart_next = pos_reg;
                        nlen_next   = NAME_LEN_BITS'(1);
                        phase_next  = P_NAME;
                    end
                    else if (step_byte == CHAR_NEWLINE)
                    begin
                        mode_next   = M_NAME;
                        stot_next   = '0;
                        sstart_next = pos_adv;
                        phase_next  = P_START;
                    end
                end
                P_NAME:
                begin
                    if (!byte_space)
                    begin
                        if (nlen_reg != NAME_MAX)
                            nlen_next = nlen_reg + 1'b1;
                    end
                    else
                    begin
                        mode_next   = M_NAME;
                        stot_next   = '0;
                        sstart_next = pos_adv;
                        phase_next  = (step_byte == CHAR_NEWLINE) ? P_START : P_HDRREST;
                    end
                end
                P_HDRREST:
                begin
                    if (step_byte == CHAR_NEWLINE)
                    begin
                        sstart_next = pos_adv;
                        phase_next  = P_START;
                    end
                end
                P_PLUSREST:
                begin
                    if (step_byte == CHAR_NEWLINE)
                    begin
                        qstart_next = pos_adv;
                        phase_next  = P_START;
                    end
                end
                P_SEQLINE:
                begin
                    if (step_byte == CHAR_NEWLINE)
                    begin
                        phase_next = P_START;
                        if (seq_end_err)
                            err = ERR_SEQ_LEN;
                        else
                        begin
                            stot_next = seq_total_sum;
                            mode_next = seq_end_mode;
                            if (mode_reg == M_NAME)
                            begin
                                flb_next  = {1'b0, l1};
                                flba_next = {1'b0, l2};
                            end
                        end
                    end
                    else
                    begin
                        clb_next  = line_bytes_inc;
                        clba_next = line_bases_inc;
                    end
                end
                P_QUALLINE:
                begin
                    if (step_byte == CHAR_NEWLINE)
                    begin
                        phase_next = P_START;
                        if (qual_end_err)
                            err = ERR_QUAL_LEN;
                        else
                            mode_next = qual_end_mode;
                    end
                    else
                    begin
                        clb_next  = line_bytes_inc;
                        clba_next = line_bases_inc;
                    end
                end
                default:
                    phase_next = P_START;
            endcase

            pos_next = pos_adv;
            if (err != ERR_NONE)
            begin
                halted_next = 1'b1;
                push.count  = 2'd1;
                push.first  = make_status(KIND_ERROR, err);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_SEQ;
            phase_reg  <= P_START;
            pos_reg    <= '0;
            stot_reg   <= '1;
            flb_reg    <= '1;
            flba_reg   <= '1;
            clb_reg    <= '0;
            clba_reg   <= '0;
            sstart_reg <= '0;
            qstart_reg <= '0;
            nstart_reg <= '0;
            nlen_reg   <= '0;
            nseen_reg  <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            stot_reg   <= stot_next;
            flb_reg    <= flb_next;
            flba_reg   <= flba_next;
            clb_reg    <= clb_next;
            clba_reg   <= clba_next;
            sstart_reg <= sstart_next;
            qstart_reg <= qstart_next;
            nstart_reg <= nstart_next;
            nlen_reg   <= nlen_next;
            nseen_reg  <= nseen_next;
            halted_reg <= halted_next;
        end
    end

endmodule

[hw/rtl/fqri_result_fifo.sv]
// small result queue: up to two writes and one read per cycle
`timescale 1ns / 1ps

module fqri_result_fifo import fqri_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  push_t                    push,
    input  logic                     pop,
    output result_t                  head,
    output logic                     not_empty,
    output logic [FIFO_CNT_BITS-1:0] count
);

    result_t                  entries [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_plus;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_plus = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next  = count_reg + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entries[wr_ptr_plus] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = entries[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

[hw/rtl/fastq_record_index_scanner_core.sv]
// top level of the fastq record index scanner
`timescale 1ns / 1ps

// usage:
// - stream carries one text byte per transaction (data_byte); a transaction with
//   end_of_stream set flushes the last record, reports finished or error, and
//   returns the scanner to its reset state (its data_byte is ignored)
// - result carries one index entry or status per transaction; last_of_run marks
//   the final result caused by one stream transaction
// - a byte taken from the stream is held in the input register, then updates the record
//   state and the result queue, from whose head its first result can leave
// - throughput: one byte per cycle while the queue has room; the rate is set by
//   the record state update and by the four-entry result queue, which must keep
//   room for two results of the byte in the input register plus two of the next one
// - a result leaving in the same cycle frees its entry for that count, so
//   results that drain as fast as they arrive never slow the input
// - an end marker gives up to two results, so it can use two result transactions
// - when the receiver stalls, results wait in the queue and stream.ready drops
//   once the queue could no longer absorb the worst case; nothing is lost
// - after an error, bytes are taken and dropped until the end marker
// - rst_n clears the input valid flag, the queue pointers and all record state;
//   byte positions count from zero after reset or after an end marker

module fastq_record_index_scanner_core import fqri_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    fqri_stream_if.sink     stream,
    fqri_result_if.source   result
);

    // input register
    logic                     s1_valid_reg;
    logic [7:0]               s1_byte_reg;
    logic                     s1_eos_reg;

    push_t                    push;
    result_t                  head;
    logic                     head_valid;
    logic [FIFO_CNT_BITS-1:0] fifo_count;
    logic [FIFO_CNT_BITS:0]   committed;
    logic                     in_fire;
    logic                     out_fire;

    // queue entries already claimed, counting the byte still in the input register
    // and giving back the entry that leaves at this edge
    assign committed = {1'b0, fifo_count} + (s1_valid_reg ? (FIFO_CNT_BITS+1)'(2)
                                                          : (FIFO_CNT_BITS+1)'(0))
                       - (FIFO_CNT_BITS+1)'(out_fire);
    assign stream.ready = (committed <= (FIFO_CNT_BITS+1)'(FIFO_DEPTH - 2));
    assign in_fire  = stream.valid && stream.ready;
    assign out_fire = head_valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_fire;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= stream.data_byte;
            s1_eos_reg  <= stream.end_of_stream;
        end
    end

    fqri_scanner u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (s1_valid_reg),
        .step_byte  (s1_byte_reg),
        .step_eos   (s1_eos_reg),
        .push       (push)
    );

    fqri_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_fire),
        .head      (head),
        .not_empty (head_valid),
        .count     (fifo_count)
    );

    // result channel straight from the queue head
    assign result.valid          = head_valid;
    assign result.result_kind    = head.result_kind;
    assign result.error_code     = head.error_code;
    assign result.name_start     = head.name_start;
    assign result.name_length    = head.name_length;
    assign result.base_count     = head.base_count;
    assign result.line_bytes     = head.line_bytes;
    assign result.line_bases     = head.line_bases;
    assign result.sequence_start = head.sequence_start;
    assign result.quality_start  = head.quality_start;
    assign result.last_of_run    = head.last_of_run;

endmodule
